// File: rtl/core/dmx_pkg.sv
// Package for the eight-to-stereo downmix unit: sample, gain, product and
// accumulator types, channel numbering, gain reset values and rounding constants.
// No dependencies.
package dmx_pkg;

  localparam int NumChannels = 8;
  localparam int SampleBits  = 16;
  localparam int GainBits    = 18;
  localparam int ProdBits    = SampleBits + GainBits;
  localparam int AccBits     = ProdBits + 3;
  localparam int ChIdxBits   = $clog2(NumChannels);
  localparam int CfgIdxBits  = ChIdxBits + 1;
  localparam int FracShift   = 15;

  // clamp to 16 bits when set, otherwise keep the low bits of the rounded sum
  localparam logic Saturate = 1'b1;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [GainBits-1:0]   gain_t;
  typedef logic signed [ProdBits-1:0]   prod_t;
  typedef logic signed [AccBits-1:0]    acc_t;
  typedef logic [CfgIdxBits-1:0]        cfg_idx_t;

  localparam int ChFrontLeft     = 0;
  localparam int ChFrontRight    = 1;
  localparam int ChCenter        = 2;
  localparam int ChLfe           = 3;
  localparam int ChSurroundLeft  = 4;
  localparam int ChSurroundRight = 5;
  localparam int ChRearLeft      = 6;
  localparam int ChRearRight     = 7;

  localparam gain_t UnityGain = gain_t'(32768);
  localparam gain_t ZeroGain  = '0;

  localparam gain_t GainReset [NumChannels] = '{
    UnityGain, UnityGain, ZeroGain, ZeroGain,
    ZeroGain, ZeroGain, ZeroGain, ZeroGain
  };

  localparam acc_t RoundBias = acc_t'(16384);
  localparam acc_t SatMax    = acc_t'(32767);
  localparam acc_t SatMin    = -acc_t'(32768);

endpackage

// File: rtl/core/dmx_gain_regs.sv
// Gain register file of the downmix unit, written through the config port.
// Depends on dmx_pkg.
module dmx_gain_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  dmx_pkg::cfg_idx_t cfg_index_i,
  input  dmx_pkg::gain_t   cfg_data_i,
  output dmx_pkg::gain_t   gain_o [dmx_pkg::NumChannels]
);
  import dmx_pkg::*;

  gain_t gain_q [NumChannels];
  logic  wr_en;

  assign cfg_ready_o = 1'b1;
  // indexes past the last gain are dropped
  assign wr_en = cfg_valid_i && (cfg_index_i < cfg_idx_t'(NumChannels));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        gain_q[i] <= GainReset[i];
      end
    end else if (wr_en) begin
      gain_q[cfg_index_i[ChIdxBits-1:0]] <= cfg_data_i;
    end
  end

  assign gain_o = gain_q;

`ifndef SYNTH
  a_no_write_past_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_index_i[CfgIdxBits-1]) |=> $stable(gain_q[0]) && $stable(gain_q[1]))
    else $error("gain register changed on out-of-range index");
  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config port stalled");
  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && cfg_index_i == cfg_idx_t'(ChFrontLeft)) |=> gain_q[ChFrontLeft] == $past(cfg_data_i))
    else $error("front left gain write lost");
`endif

endmodule

// File: rtl/core/dmx_prod_stage.sv
// Input register and product register of the downmix pipeline: latches one
// frame, then forms the eight sample-by-gain products. Depends on dmx_pkg.
module dmx_prod_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  dmx_pkg::sample_t smp_i [dmx_pkg::NumChannels],
  input  logic             last_i,
  input  dmx_pkg::gain_t   gain_i [dmx_pkg::NumChannels],
  output logic             valid_o,
  input  logic             ready_i,
  output dmx_pkg::prod_t   prod_o [dmx_pkg::NumChannels],
  output logic             last_o
);
  import dmx_pkg::*;

  logic    a_valid_q, a_valid_d;
  sample_t a_smp_q [NumChannels];
  logic    a_last_q;
  logic    b_valid_q, b_valid_d;
  prod_t   b_prod_q [NumChannels];
  logic    b_last_q;
  logic    a_load, b_en;

  assign b_en    = !b_valid_q || ready_i;
  assign ready_o = !a_valid_q || b_en;
  assign a_load  = valid_i && ready_o;

  always_comb begin
    a_valid_d = a_valid_q;
    b_valid_d = b_valid_q;
    if (ready_o) begin
      a_valid_d = valid_i;
    end
    if (b_en) begin
      b_valid_d = a_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_smp_q  <= smp_i;
      a_last_q <= last_i;
    end
    if (b_en && a_valid_q) begin
      for (int i = 0; i < NumChannels; i++) begin
        b_prod_q[i] <= prod_t'(a_smp_q[i]) * prod_t'(gain_i[i]);
      end
      b_last_q <= a_last_q;
    end
  end

  assign valid_o = b_valid_q;
  assign prod_o  = b_prod_q;
  assign last_o  = b_last_q;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (a_valid_q && b_valid_q && !ready_i))
    else $error("input stalled with room in pipeline");
  a_stage_a_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_en) |=> (a_valid_q && $stable(a_last_q)))
    else $error("stalled frame lost from input register");
  a_stage_b_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !ready_i) |=> (b_valid_q && $stable(b_last_q)))
    else $error("stalled products lost");
`endif

endmodule

// File: rtl/core/dmx_mix_stage.sv
// Result stage of the downmix pipeline: sums products per side, rounds by
// 15 bits, saturates or wraps, and holds the stereo pair. Depends on dmx_pkg.
module dmx_mix_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  dmx_pkg::prod_t   prod_i [dmx_pkg::NumChannels],
  input  logic             last_i,
  output logic             valid_o,
  input  logic             ready_i,
  output dmx_pkg::sample_t left_o,
  output dmx_pkg::sample_t right_o,
  output logic             last_o
);
  import dmx_pkg::*;

  logic    out_valid_q, out_valid_d;
  sample_t left_q, right_q;
  logic    last_q;
  acc_t    shared, acc_l, acc_r, rnd_l, rnd_r;
  logic    load;

  function automatic sample_t finish(acc_t rnd);
    sample_t res;
    res = rnd[SampleBits-1:0];
    if (Saturate) begin
      if (rnd > SatMax) begin
        res = SatMax[SampleBits-1:0];
      end else if (rnd < SatMin) begin
        res = SatMin[SampleBits-1:0];
      end
    end
    return res;
  endfunction

  always_comb begin
    shared = acc_t'(prod_i[ChCenter]) + acc_t'(prod_i[ChLfe]);
    acc_l  = shared + acc_t'(prod_i[ChFrontLeft]) + acc_t'(prod_i[ChSurroundLeft])
           + acc_t'(prod_i[ChRearLeft]);
    acc_r  = shared + acc_t'(prod_i[ChFrontRight]) + acc_t'(prod_i[ChSurroundRight])
           + acc_t'(prod_i[ChRearRight]);
    rnd_l  = (acc_l + RoundBias) >>> FracShift;
    rnd_r  = (acc_r + RoundBias) >>> FracShift;
  end

  assign ready_o = !out_valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ready_o) begin
      out_valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      left_q  <= finish(rnd_l);
      right_q <= finish(rnd_r);
      last_q  <= last_i;
    end
  end

  assign valid_o = out_valid_q;
  assign left_o  = left_q;
  assign right_o = right_q;
  assign last_o  = last_q;

`ifndef SYNTH
  a_sat_sign_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (!Saturate || left_q[SampleBits-1] == $past(rnd_l[AccBits-1])))
    else $error("left saturation flipped sign");
  a_sat_sign_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (!Saturate || right_q[SampleBits-1] == $past(rnd_r[AccBits-1])))
    else $error("right saturation flipped sign");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ready_i) |=> (out_valid_q && $stable(left_q) && $stable(right_q)))
    else $error("pending result overwritten");
`endif

endmodule

// File: rtl/core/eight_to_stereo_downmix_unit.sv
// Eight-channel to stereo downmix, top level.
// Depends on dmx_pkg, dmx_gain_regs, dmx_prod_stage, dmx_mix_stage.
//
// Takes one frame of eight signed 16-bit samples per request and returns one
// stereo pair per frame, sustaining one frame per clock while the output is not
// stalled. A frame accepted at the input passes the input register, the product
// register (eight 16x18 multipliers), then the result register where
// each side's five products are summed, rounded by (sum + 16384) >>> 15 and
// saturated to 16 bits.
// Gains are 18-bit signed Q15 values written through the config port at index
// 0..7 (front left, front right, center, LFE, surround left/right, rear
// left/right); writes to higher indexes are ignored. Write gains only while no
// frame is in flight. For six-channel content leave both rear gains at zero.
module eight_to_stereo_downmix_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  dmx_pkg::cfg_idx_t cfg_index_i,
  input  dmx_pkg::gain_t    cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dmx_pkg::sample_t  ch0_sample_i,
  input  dmx_pkg::sample_t  ch1_sample_i,
  input  dmx_pkg::sample_t  ch2_sample_i,
  input  dmx_pkg::sample_t  ch3_sample_i,
  input  dmx_pkg::sample_t  ch4_sample_i,
  input  dmx_pkg::sample_t  ch5_sample_i,
  input  dmx_pkg::sample_t  ch6_sample_i,
  input  dmx_pkg::sample_t  ch7_sample_i,
  input  logic              frame_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dmx_pkg::sample_t  left_sample_o,
  output dmx_pkg::sample_t  right_sample_o,
  output logic              out_last_o
);
  import dmx_pkg::*;

  gain_t   gain   [NumChannels];
  sample_t smp    [NumChannels];
  prod_t   prod   [NumChannels];
  logic    prod_valid, prod_ready, prod_last;

  assign smp[ChFrontLeft]     = ch0_sample_i;
  assign smp[ChFrontRight]    = ch1_sample_i;
  assign smp[ChCenter]        = ch2_sample_i;
  assign smp[ChLfe]           = ch3_sample_i;
  assign smp[ChSurroundLeft]  = ch4_sample_i;
  assign smp[ChSurroundRight] = ch5_sample_i;
  assign smp[ChRearLeft]      = ch6_sample_i;
  assign smp[ChRearRight]     = ch7_sample_i;

  dmx_gain_regs u_gain_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .gain_o      (gain)
  );

  dmx_prod_stage u_prod_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .smp_i   (smp),
    .last_i  (frame_last_i),
    .gain_i  (gain),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .prod_o  (prod),
    .last_o  (prod_last)
  );

  dmx_mix_stage u_mix_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .prod_i  (prod),
    .last_i  (prod_last),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .left_o  (left_sample_o),
    .right_o (right_sample_o),
    .last_o  (out_last_o)
  );

endmodule
